[hdl/mfs_pkg.sv]
// ----------------------------------------------------------------------------
// mfs_pkg
// shared types and codes for the mirror fold sequencer
// ----------------------------------------------------------------------------
package mfs_pkg;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned DATA_W = 16;

    typedef logic [POS_W-1:0] t_pos;

    // item kinds
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_FOLD   = 2'd1,
        OP_UNFOLD = 2'd2,
        OP_CANCEL = 2'd3
    } t_opcode;

    // movement commands
    typedef enum logic [1:0] {
        CMD_IDLE   = 2'd0,
        CMD_FOLD   = 2'd1,
        CMD_UNFOLD = 2'd2
    } t_cmd;

    // abort reasons
    typedef enum logic [2:0] {
        AB_NONE        = 3'd0,
        AB_LOW_PRIO    = 3'd1,
        AB_POS_ERROR   = 3'd2,
        AB_UNREACHABLE = 3'd3,
        AB_REACHED     = 3'd4
    } t_abort;

    // glass adjust status codes
    localparam logic [1:0] GLASS_RUNNING  = 2'd0;
    localparam logic [1:0] GLASS_FINISHED = 2'd1;
    localparam logic [1:0] GLASS_ABORTED  = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FOLD_OFFSET     = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEFAULT_DRIVE_X = 3'd1;
    localparam logic [IDX_W-1:0] REG_DEFAULT_DRIVE_Y = 3'd2;
    localparam logic [IDX_W-1:0] REG_GLASS_PRIORITY  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FOLD_LOW_STOP_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_UPPER_STOP_Y    = 3'd5;
    localparam logic [IDX_W-1:0] REG_LOWER_STOP_Y    = 3'd6;
    localparam logic [IDX_W-1:0] REG_BLOCK_DETECT    = 3'd7;

endpackage

[hdl/mirror_fold_sequencer_top.sv]
// ----------------------------------------------------------------------------
// mirror_fold_sequencer_top
// fold / unfold sequencer with abort checks, position save and glass follow
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -------------------------------
//  in        in         i_in_valid / o_in_ready   opcode, adjust, status, position
//  out       out        o_out_valid / i_out_ready accepted, commands, targets ...
//  cfg       in         i_cfg_we                  i_cfg_index, i_cfg_data
//
//  one transaction per cycle sustained while the result side keeps taking
//  results; each input passes the input register, then the result register
//  the decision logic plus the 16-bit fold target and y midpoint adds sit
//  between the two registers; state updates when the input stage advances
//  reset is synchronous, active low; clears control state and all settings
//  a stalled result holds the input stage, which in turn drops o_in_ready
//
module mirror_fold_sequencer_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  mfs_pkg::t_opcode           i_opcode,
    input  logic                       i_manual_adjust_req,
    input  logic                       i_auto_adjust_req,
    input  logic                       i_position_error,
    input  logic                       i_motor_blocked,
    input  logic [1:0]                 i_glass_status,
    input  logic                       i_storage_busy,
    input  mfs_pkg::t_pos              i_current_x,
    input  mfs_pkg::t_pos              i_current_y,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_accepted,
    output mfs_pkg::t_cmd              o_pending_cmd_out,
    output mfs_pkg::t_cmd              o_active_cmd_out,
    output logic                       o_auto_adjust_on,
    output mfs_pkg::t_pos              o_target_x_out,
    output mfs_pkg::t_pos              o_target_y_out,
    output mfs_pkg::t_abort            o_abort_reason_out,
    output logic                       o_storage_write,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [mfs_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [mfs_pkg::DATA_W-1:0] i_cfg_data
);
    import mfs_pkg::*;

    // settings
    t_pos r_fold_offset;
    t_pos r_default_drive_x;
    t_pos r_default_drive_y;
    logic r_glass_has_priority;
    t_pos r_fold_low_stop_x;
    t_pos r_upper_stop_y;
    t_pos r_lower_stop_y;
    logic r_block_detect_enable;

    // input stage
    logic       r_in_valid;
    t_opcode    r_opcode;
    logic       r_adj_req;
    logic       r_position_error;
    logic       r_motor_blocked;
    logic [1:0] r_glass_status;
    logic       r_storage_busy;
    t_pos       r_current_x;
    t_pos       r_current_y;

    // sequencer state
    t_cmd   r_pending_cmd,  n_pending_cmd;
    t_cmd   r_previous_cmd, n_previous_cmd;
    t_cmd   r_active_cmd,   n_active_cmd;
    logic   r_auto_flag,    n_auto_flag;
    t_abort r_abort_reason, n_abort_reason;
    t_pos   r_target_x,     n_target_x;
    t_pos   r_target_y,     n_target_y;
    t_pos   r_saved_x,      n_saved_x;
    t_pos   r_saved_y,      n_saved_y;
    logic   r_save_allowed, n_save_allowed;
    logic   n_accepted;
    logic   n_storage_write;

    // result register
    logic   r_out_valid;
    logic   r_accepted;
    logic   r_storage_write;

    logic   w_advance;
    t_abort w_reason;
    logic   w_is_new;
    logic [POS_W:0] w_y_sum;
    t_pos   w_fold_x;

    // the input stage moves on when the result register is free or being taken
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_offset         <= '0;
            r_default_drive_x     <= '0;
            r_default_drive_y     <= '0;
            r_glass_has_priority  <= 1'b0;
            r_fold_low_stop_x     <= '0;
            r_upper_stop_y        <= '0;
            r_lower_stop_y        <= '0;
            r_block_detect_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FOLD_OFFSET:     r_fold_offset         <= i_cfg_data[POS_W-1:0];
                REG_DEFAULT_DRIVE_X: r_default_drive_x     <= i_cfg_data[POS_W-1:0];
                REG_DEFAULT_DRIVE_Y: r_default_drive_y     <= i_cfg_data[POS_W-1:0];
                REG_GLASS_PRIORITY:  r_glass_has_priority  <= i_cfg_data[0];
                REG_FOLD_LOW_STOP_X: r_fold_low_stop_x     <= i_cfg_data[POS_W-1:0];
                REG_UPPER_STOP_Y:    r_upper_stop_y        <= i_cfg_data[POS_W-1:0];
                REG_LOWER_STOP_Y:    r_lower_stop_y        <= i_cfg_data[POS_W-1:0];
                REG_BLOCK_DETECT:    r_block_detect_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register; manual and auto requests are merged into one adjust request (OR)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_opcode         <= i_opcode;
            r_adj_req        <= i_manual_adjust_req | i_auto_adjust_req;
            r_position_error <= i_position_error;
            r_motor_blocked  <= i_motor_blocked;
            r_glass_status   <= i_glass_status;
            r_storage_busy   <= i_storage_busy;
            r_current_x      <= i_current_x;
            r_current_y      <= i_current_y;
        end
    end

    // fold targets: x wraps at 16 bits, y midpoint from a 17-bit sum
    assign w_fold_x = r_fold_low_stop_x + r_fold_offset;
    assign w_y_sum  = {1'b0, r_upper_stop_y} + {1'b0, r_lower_stop_y};
    assign w_is_new = (r_pending_cmd != r_previous_cmd);

    // abort check in priority order
    always_comb begin
        if (r_position_error) begin
            w_reason = AB_POS_ERROR;
        end else if (r_adj_req && !r_glass_has_priority && !r_auto_flag &&
                     r_pending_cmd != CMD_IDLE) begin
            w_reason = AB_LOW_PRIO;
        end else if (r_block_detect_enable && r_motor_blocked) begin
            w_reason = AB_UNREACHABLE;
        end else begin
            w_reason = AB_NONE;
        end
    end

    // one step of the sequencer
    always_comb begin
        n_pending_cmd   = r_pending_cmd;
        n_previous_cmd  = r_previous_cmd;
        n_active_cmd    = r_active_cmd;
        n_auto_flag     = r_auto_flag;
        n_abort_reason  = r_abort_reason;
        n_target_x      = r_target_x;
        n_target_y      = r_target_y;
        n_saved_x       = r_saved_x;
        n_saved_y       = r_saved_y;
        n_save_allowed  = r_save_allowed;
        n_accepted      = 1'b0;
        n_storage_write = 1'b0;

        case (r_opcode)
            OP_TICK: begin
                if (w_reason != AB_NONE) begin
                    n_pending_cmd  = CMD_IDLE;
                    n_active_cmd   = CMD_IDLE;
                    n_auto_flag    = 1'b0;
                    n_abort_reason = w_reason;
                end else if (r_pending_cmd == CMD_FOLD && w_is_new) begin
                    // position saved once per fold until re-allowed
                    if (!r_storage_busy && r_save_allowed) begin
                        n_saved_x       = r_current_x;
                        n_saved_y       = r_current_y;
                        n_save_allowed  = 1'b0;
                        n_storage_write = 1'b1;
                    end
                    n_target_x     = w_fold_x;
                    n_target_y     = w_y_sum[POS_W:1];
                    n_auto_flag    = 1'b1;
                    n_active_cmd   = CMD_FOLD;
                    n_abort_reason = AB_NONE;
                end else if (r_pending_cmd == CMD_UNFOLD && w_is_new) begin
                    // zero in either saved axis means nothing saved
                    if (r_saved_x != '0 && r_saved_y != '0) begin
                        n_target_x = r_saved_x;
                        n_target_y = r_saved_y;
                    end else begin
                        n_target_x = r_default_drive_x;
                        n_target_y = r_default_drive_y;
                    end
                    n_active_cmd   = CMD_UNFOLD;
                    n_auto_flag    = 1'b1;
                    n_abort_reason = AB_NONE;
                end else if (r_auto_flag) begin
                    if (r_glass_status == GLASS_FINISHED) begin
                        n_pending_cmd  = CMD_IDLE;
                        n_active_cmd   = CMD_IDLE;
                        n_auto_flag    = 1'b0;
                        n_abort_reason = AB_REACHED;
                    end else if (r_glass_status == GLASS_ABORTED) begin
                        n_pending_cmd  = CMD_IDLE;
                        n_active_cmd   = CMD_IDLE;
                        n_auto_flag    = 1'b0;
                        n_abort_reason = AB_UNREACHABLE;
                    end
                end
                // re-allow save; sees a save cleared earlier in this same tick
                if (!n_save_allowed && r_adj_req && !r_storage_busy) begin
                    n_save_allowed  = 1'b1;
                    n_storage_write = 1'b1;
                end
                n_previous_cmd = n_pending_cmd;
            end
            OP_FOLD, OP_UNFOLD: begin
                if (r_pending_cmd == CMD_IDLE) begin
                    n_pending_cmd = (r_opcode == OP_FOLD) ? CMD_FOLD : CMD_UNFOLD;
                    n_accepted    = 1'b1;
                end
            end
            OP_CANCEL: begin
                if (r_pending_cmd != CMD_IDLE) begin
                    n_pending_cmd  = CMD_IDLE;
                    n_active_cmd   = CMD_IDLE;
                    n_auto_flag    = 1'b0;
                    n_abort_reason = AB_LOW_PRIO;
                    n_accepted     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // state and result register update together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_cmd  <= CMD_IDLE;
            r_previous_cmd <= CMD_IDLE;
            r_active_cmd   <= CMD_IDLE;
            r_auto_flag    <= 1'b0;
            r_abort_reason <= AB_NONE;
            r_target_x     <= '0;
            r_target_y     <= '0;
            r_saved_x      <= '0;
            r_saved_y      <= '0;
            r_save_allowed <= 1'b1;
        end else if (w_advance) begin
            r_pending_cmd  <= n_pending_cmd;
            r_previous_cmd <= n_previous_cmd;
            r_active_cmd   <= n_active_cmd;
            r_auto_flag    <= n_auto_flag;
            r_abort_reason <= n_abort_reason;
            r_target_x     <= n_target_x;
            r_target_y     <= n_target_y;
            r_saved_x      <= n_saved_x;
            r_saved_y      <= n_saved_y;
            r_save_allowed <= n_save_allowed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_accepted      <= n_accepted;
            r_storage_write <= n_storage_write;
        end
    end

    // the result shows the state after the step, so it reads the state registers
    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_accepted;
    assign o_pending_cmd_out  = r_pending_cmd;
    assign o_active_cmd_out   = r_active_cmd;
    assign o_auto_adjust_on   = r_auto_flag;
    assign o_target_x_out     = r_target_x;
    assign o_target_y_out     = r_target_y;
    assign o_abort_reason_out = r_abort_reason;
    assign o_storage_write    = r_storage_write;

`ifndef NO_ASSERTIONS
    // a movement runs exactly while the auto adjust command is on
    a_active_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_auto_flag == (r_active_cmd != CMD_IDLE))
        else $error("active command and auto adjust flag disagree");

    // clearing the save flag always comes with a storage write
    a_save_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_save_allowed) |-> (r_out_valid && r_storage_write))
        else $error("save flag cleared without storage write");

    // state only changes when a transaction leaves the input stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_pending_cmd) && $stable(r_target_x) &&
                        $stable(r_saved_x)))
        else $error("sequencer state changed without a step");
`endif

endmodule

[sim/mfs_checker.sv]
// ----------------------------------------------------------------------------
// mfs_checker
// watches the mirror fold sequencer channels, predicts each result and
// compares it field by field against what the block returns
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mfs_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  mfs_pkg::t_opcode           i_opcode,
    input  logic                       i_manual_adjust_req,
    input  logic                       i_auto_adjust_req,
    input  logic                       i_position_error,
    input  logic                       i_motor_blocked,
    input  logic [1:0]                 i_glass_status,
    input  logic                       i_storage_busy,
    input  mfs_pkg::t_pos              i_current_x,
    input  mfs_pkg::t_pos              i_current_y,
    // result channel
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_accepted,
    input  mfs_pkg::t_cmd              i_pending_cmd_out,
    input  mfs_pkg::t_cmd              i_active_cmd_out,
    input  logic                       i_auto_adjust_on,
    input  mfs_pkg::t_pos              i_target_x_out,
    input  mfs_pkg::t_pos              i_target_y_out,
    input  mfs_pkg::t_abort            i_abort_reason_out,
    input  logic                       i_storage_write,
    // configuration writes
    input  logic                       i_cfg_we,
    input  logic [mfs_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [mfs_pkg::DATA_W-1:0] i_cfg_data,
    // status toward the testbench top
    output int                         o_open,
    output int                         o_fail_count,
    output int                         o_results
);
    import mfs_pkg::*;

    typedef struct {
        logic   accepted;
        t_cmd   pending;
        t_cmd   active;
        logic   auto_on;
        t_pos   tgt_x;
        t_pos   tgt_y;
        t_abort abort_why;
        logic   wrote;
    } t_outcome;

    t_outcome outcome_q[$];
    int       fail_cnt  = 0;
    int       n_results = 0;

    // settings copy
    t_pos c_fold_offset, c_drive_x, c_drive_y, c_low_stop_x, c_upper_y, c_lower_y;
    logic c_glass_prio, c_block_en;

    // sequencer state copy
    t_cmd   m_pending, m_previous, m_active;
    logic   m_auto, m_save_ok;
    t_abort m_abort;
    t_pos   m_tgt_x, m_tgt_y, m_saved_x, m_saved_y;

    function automatic void halt_motion(input t_abort why);
        m_auto    = 1'b0;
        m_active  = CMD_IDLE;
        m_pending = CMD_IDLE;
        m_abort   = why;
    endfunction

    function automatic t_outcome predict_outcome(
        input t_opcode    op,
        input logic       man,
        input logic       aut,
        input logic       perr,
        input logic       blk,
        input logic [1:0] glass,
        input logic       busy,
        input t_pos       cx,
        input t_pos       cy
    );
        t_outcome    r;
        logic        adj;
        logic        fresh;
        t_abort      why;
        logic [16:0] ysum;
        r.accepted = 1'b0;
        r.wrote    = 1'b0;
        case (op)
            OP_TICK: begin
                adj   = man | aut;
                fresh = (m_pending != m_previous);
                // abort reasons in priority order
                if (perr)
                    why = AB_POS_ERROR;
                else if (adj && !c_glass_prio && !m_auto && m_pending != CMD_IDLE)
                    why = AB_LOW_PRIO;
                else if (c_block_en && blk)
                    why = AB_UNREACHABLE;
                else
                    why = AB_NONE;

                if (why != AB_NONE) begin
                    halt_motion(why);
                end else if (m_pending == CMD_FOLD && fresh) begin
                    if (!busy && m_save_ok) begin
                        m_saved_x = cx;
                        m_saved_y = cy;
                        m_save_ok = 1'b0;
                        r.wrote   = 1'b1;
                    end
                    m_tgt_x  = c_low_stop_x + c_fold_offset;
                    ysum     = {1'b0, c_upper_y} + {1'b0, c_lower_y};
                    m_tgt_y  = ysum[16:1];
                    m_auto   = 1'b1;
                    m_active = CMD_FOLD;
                    m_abort  = AB_NONE;
                end else if (m_pending == CMD_UNFOLD && fresh) begin
                    if (m_saved_x != '0 && m_saved_y != '0) begin
                        m_tgt_x = m_saved_x;
                        m_tgt_y = m_saved_y;
                    end else begin
                        m_tgt_x = c_drive_x;
                        m_tgt_y = c_drive_y;
                    end
                    m_active = CMD_UNFOLD;
                    m_auto   = 1'b1;
                    m_abort  = AB_NONE;
                end else if (m_auto) begin
                    if (glass == GLASS_FINISHED)
                        halt_motion(AB_REACHED);
                    else if (glass == GLASS_ABORTED)
                        halt_motion(AB_UNREACHABLE);
                end

                // adjust request with free storage re-arms the save
                if (!m_save_ok && adj && !busy) begin
                    m_save_ok = 1'b1;
                    r.wrote   = 1'b1;
                end
                m_previous = m_pending;
            end
            OP_FOLD, OP_UNFOLD: begin
                if (m_pending == CMD_IDLE) begin
                    if (op == OP_FOLD)
                        m_pending = CMD_FOLD;
                    else
                        m_pending = CMD_UNFOLD;
                    r.accepted = 1'b1;
                end
            end
            default: begin
                if (m_pending != CMD_IDLE) begin
                    halt_motion(AB_LOW_PRIO);
                    r.accepted = 1'b1;
                end
            end
        endcase
        r.pending   = m_pending;
        r.active    = m_active;
        r.auto_on   = m_auto;
        r.tgt_x     = m_tgt_x;
        r.tgt_y     = m_tgt_y;
        r.abort_why = m_abort;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            c_fold_offset = '0;
            c_drive_x     = '0;
            c_drive_y     = '0;
            c_glass_prio  = 1'b0;
            c_low_stop_x  = '0;
            c_upper_y     = '0;
            c_lower_y     = '0;
            c_block_en    = 1'b0;
            m_pending     = CMD_IDLE;
            m_previous    = CMD_IDLE;
            m_active      = CMD_IDLE;
            m_auto        = 1'b0;
            m_abort       = AB_NONE;
            m_tgt_x       = '0;
            m_tgt_y       = '0;
            m_saved_x     = '0;
            m_saved_y     = '0;
            m_save_ok     = 1'b1;
            outcome_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FOLD_OFFSET:     c_fold_offset = i_cfg_data;
                    REG_DEFAULT_DRIVE_X: c_drive_x     = i_cfg_data;
                    REG_DEFAULT_DRIVE_Y: c_drive_y     = i_cfg_data;
                    REG_GLASS_PRIORITY:  c_glass_prio  = i_cfg_data[0];
                    REG_FOLD_LOW_STOP_X: c_low_stop_x  = i_cfg_data;
                    REG_UPPER_STOP_Y:    c_upper_y     = i_cfg_data;
                    REG_LOWER_STOP_Y:    c_lower_y     = i_cfg_data;
                    REG_BLOCK_DETECT:    c_block_en    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s=%0b pending=%0d",
                             $time, "actual accepted", i_accepted, i_pending_cmd_out);
                    fail_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("accepted", want.accepted, i_accepted);
                    check_field("pending_cmd", want.pending, i_pending_cmd_out);
                    check_field("active_cmd", want.active, i_active_cmd_out);
                    check_field("auto_adjust_on", want.auto_on, i_auto_adjust_on);
                    check_field("target_x", want.tgt_x, i_target_x_out);
                    check_field("target_y", want.tgt_y, i_target_y_out);
                    check_field("abort_reason", want.abort_why, i_abort_reason_out);
                    check_field("storage_write", want.wrote, i_storage_write);
                    n_results++;
                end
            end
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(predict_outcome(i_opcode, i_manual_adjust_req,
                    i_auto_adjust_req, i_position_error, i_motor_blocked, i_glass_status,
                    i_storage_busy, i_current_x, i_current_y));
        end
        o_open       <= outcome_q.size();
        o_fail_count <= fail_cnt;
        o_results    <= n_results;
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives fold, unfold, cancel and tick transactions into the mirror fold
// sequencer under several register setups with random idling on both
// channels; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import mfs_pkg::*;

    // glass status code the block treats like running
    localparam logic [1:0] GLASS_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS  = 205;

    // one input transaction
    typedef struct {
        t_opcode    op;
        logic       man;
        logic       aut;
        logic       perr;
        logic       blk;
        logic [1:0] glass;
        logic       busy;
        t_pos       cx;
        t_pos       cy;
    } t_item;

    // one full register setup
    typedef struct {
        t_pos fold_offset;
        t_pos drive_x;
        t_pos drive_y;
        logic glass_prio;
        t_pos low_stop_x;
        t_pos upper_y;
        t_pos lower_y;
        logic block_en;
    } t_setup;

    logic              clk;
    logic              rst_n     = 1'b0;
    // input channel
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_opcode           opcode    = OP_TICK;
    logic              man_req   = 1'b0;
    logic              auto_req  = 1'b0;
    logic              pos_err   = 1'b0;
    logic              blocked   = 1'b0;
    logic [1:0]        glass     = GLASS_RUNNING;
    logic              busy      = 1'b0;
    t_pos              cur_x     = '0;
    t_pos              cur_y     = '0;
    // result channel
    logic              out_valid;
    logic              out_ready = 1'b1;
    logic              accepted;
    t_cmd              pending_cmd;
    t_cmd              active_cmd;
    logic              auto_on;
    t_pos              target_x;
    t_pos              target_y;
    t_abort            abort_why;
    logic              storage_write;
    // configuration port
    logic              cfg_we    = 1'b0;
    logic [IDX_W-1:0]  cfg_index = REG_FOLD_OFFSET;
    logic [DATA_W-1:0] cfg_data  = '0;

    // run bookkeeping
    int open_cnt;
    int fail_count;
    int results_seen;
    int items_sent = 0;
    int setups     = 0;
    int cycle_cnt  = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int hold_cnt   = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    mirror_fold_sequencer_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_opcode            (opcode),
        .i_manual_adjust_req (man_req),
        .i_auto_adjust_req   (auto_req),
        .i_position_error    (pos_err),
        .i_motor_blocked     (blocked),
        .i_glass_status      (glass),
        .i_storage_busy      (busy),
        .i_current_x         (cur_x),
        .i_current_y         (cur_y),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_accepted          (accepted),
        .o_pending_cmd_out   (pending_cmd),
        .o_active_cmd_out    (active_cmd),
        .o_auto_adjust_on    (auto_on),
        .o_target_x_out      (target_x),
        .o_target_y_out      (target_y),
        .o_abort_reason_out  (abort_why),
        .o_storage_write     (storage_write),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    mfs_checker fold_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_opcode            (opcode),
        .i_manual_adjust_req (man_req),
        .i_auto_adjust_req   (auto_req),
        .i_position_error    (pos_err),
        .i_motor_blocked     (blocked),
        .i_glass_status      (glass),
        .i_storage_busy      (busy),
        .i_current_x         (cur_x),
        .i_current_y         (cur_y),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_accepted          (accepted),
        .i_pending_cmd_out   (pending_cmd),
        .i_active_cmd_out    (active_cmd),
        .i_auto_adjust_on    (auto_on),
        .i_target_x_out      (target_x),
        .i_target_y_out      (target_y),
        .i_abort_reason_out  (abort_why),
        .i_storage_write     (storage_write),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_open              (open_cnt),
        .o_fail_count        (fail_count),
        .o_results           (results_seen)
    );

    // result side back-pressure: ready drops for bursts of random length
    always @(posedge clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            if (hold_cnt == 1)
                out_ready <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            out_ready <= 1'b0;
            hold_cnt  <= $urandom_range(1, 18);
        end
    end

    // watchdog, sized from the slowest legal run with a wide margin
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_item make_item(input t_opcode op, input logic man, input logic aut,
                                        input logic perr, input logic blk,
                                        input logic [1:0] gl, input logic bsy,
                                        input t_pos cx, input t_pos cy);
        t_item it;
        it.op    = op;
        it.man   = man;
        it.aut   = aut;
        it.perr  = perr;
        it.blk   = blk;
        it.glass = gl;
        it.busy  = bsy;
        it.cx    = cx;
        it.cy    = cy;
        return it;
    endfunction

    // random tick; flag_pct sets how often each abort-type flag is raised
    function automatic t_item tick_item(input int unsigned flag_pct);
        t_item       it;
        int unsigned pick;
        it.op   = OP_TICK;
        it.man  = ($urandom_range(0, 99) < flag_pct);
        it.aut  = ($urandom_range(0, 99) < flag_pct);
        it.perr = ($urandom_range(0, 99) < flag_pct);
        it.blk  = ($urandom_range(0, 99) < flag_pct);
        it.busy = ($urandom_range(0, 99) < 30);
        pick = $urandom_range(0, 19);
        // mostly running so a movement lasts a few ticks
        if (pick < 12)
            it.glass = GLASS_RUNNING;
        else if (pick < 16)
            it.glass = GLASS_FINISHED;
        else if (pick < 19)
            it.glass = GLASS_ABORTED;
        else
            it.glass = GLASS_UNUSED;
        // zero positions now and then so unfold falls back to the defaults
        it.cx = ($urandom_range(0, 15) == 0) ? t_pos'(0) : t_pos'($urandom);
        it.cy = ($urandom_range(0, 15) == 0) ? t_pos'(0) : t_pos'($urandom);
        return it;
    endfunction

    function automatic t_setup rand_setup(input logic gp, input logic be);
        t_setup s;
        s.fold_offset = t_pos'($urandom);
        s.drive_x     = t_pos'($urandom);
        s.drive_y     = t_pos'($urandom);
        s.glass_prio  = gp;
        s.low_stop_x  = t_pos'($urandom);
        s.upper_y     = t_pos'($urandom);
        s.lower_y     = t_pos'($urandom);
        s.block_en    = be;
        return s;
    endfunction

    // hold one transaction until accepted, then maybe leave a gap
    task automatic send(input t_item it);
        in_valid <= 1'b1;
        opcode   <= it.op;
        man_req  <= it.man;
        auto_req <= it.aut;
        pos_err  <= it.perr;
        blocked  <= it.blk;
        glass    <= it.glass;
        busy     <= it.busy;
        cur_x    <= it.cx;
        cur_y    <= it.cy;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        items_sent++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // drain the block, then rewrite every register
    task automatic reconfigure(input t_setup s);
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_cnt != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_reg(REG_FOLD_OFFSET, s.fold_offset);
        put_reg(REG_DEFAULT_DRIVE_X, s.drive_x);
        put_reg(REG_DEFAULT_DRIVE_Y, s.drive_y);
        put_reg(REG_GLASS_PRIORITY, {{(DATA_W-1){1'b0}}, s.glass_prio});
        put_reg(REG_FOLD_LOW_STOP_X, s.low_stop_x);
        put_reg(REG_UPPER_STOP_Y, s.upper_y);
        put_reg(REG_LOWER_STOP_Y, s.lower_y);
        put_reg(REG_BLOCK_DETECT, {{(DATA_W-1){1'b0}}, s.block_en});
        cfg_we <= 1'b0;
        setups++;
    endtask

    // mostly a request followed by a handful of ticks, sometimes pure noise
    task automatic run_episode();
        t_item it;
        if ($urandom_range(0, 9) < 8) begin
            it    = tick_item(50);
            it.op = ($urandom_range(0, 99) < 55) ? OP_FOLD : OP_UNFOLD;
            send(it);
            if ($urandom_range(0, 9) == 0) begin
                it    = tick_item(50);
                it.op = OP_CANCEL;
                send(it);
            end
            repeat ($urandom_range(1, 7)) begin
                if ($urandom_range(0, 11) == 0) begin
                    it    = tick_item(50);
                    it.op = t_opcode'($urandom_range(0, 3));
                    send(it);
                end else begin
                    send(tick_item(6));
                end
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                it    = tick_item(50);
                it.op = t_opcode'($urandom_range(0, 3));
                send(it);
            end
        end
    endtask

    task automatic run_phase(input t_setup s, input int gap, input int stall);
        int goal;
        reconfigure(s);
        gap_pct   = gap;
        stall_pct <= stall;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) run_episode();
    endtask

    initial begin : stimulus
        t_setup wrap_setup;
        t_setup zero_setup;
        t_setup full_setup;
        // wrapping fold target, y midpoint needing the carry bit
        wrap_setup = '{16'hFFFF, 16'h1234, 16'hABCD, 1'b0,
                       16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
        zero_setup = '{16'h0000, 16'h0000, 16'h0000, 1'b0,
                       16'h0000, 16'h0000, 16'h0000, 1'b0};
        full_setup = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                       16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed sequence, no idling
        reconfigure(wrap_setup);
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        // cancel while idle is refused
        send(make_item(OP_CANCEL, 1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        send(make_item(OP_FOLD,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        // second request while one is pending is refused
        send(make_item(OP_UNFOLD, 1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        // fold starts and saves the position
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0,
                       16'hFFFF, 16'h0001));
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        // unused glass code behaves like running
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_UNUSED, 1'b0, '0, '0));
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_FINISHED, 1'b0, '0, '0));
        // unfold goes back to the saved position
        send(make_item(OP_UNFOLD, 1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        // blocked motor with detection on
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b1, GLASS_RUNNING, 1'b0, '0, '0));
        // manual adjust before the fold starts aborts as low priority
        send(make_item(OP_FOLD,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        send(make_item(OP_TICK,   1'b1, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b1, '0, '0));
        // adjust request with free storage re-arms the save
        send(make_item(OP_TICK,   1'b0, 1'b1, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        // fold while storage is busy: no save
        send(make_item(OP_FOLD,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b1,
                       16'h5555, 16'hAAAA));
        // position error outranks every other abort
        send(make_item(OP_TICK,   1'b1, 1'b1, 1'b1, 1'b1, GLASS_RUNNING, 1'b0, '0, '0));
        // save a zero x so the next unfold uses the defaults
        send(make_item(OP_FOLD,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0,
                       16'h0000, 16'h8000));
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_ABORTED, 1'b0, '0, '0));
        send(make_item(OP_UNFOLD, 1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        send(make_item(OP_TICK,   1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        send(make_item(OP_UNFOLD, 1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));
        // cancel of a running movement
        send(make_item(OP_CANCEL, 1'b0, 1'b0, 1'b0, 1'b0, GLASS_RUNNING, 1'b0, '0, '0));

        // random phases, idling mix changes per phase, last one runs flat out
        run_phase(rand_setup(1'b1, 1'b0), 15, 10);
        run_phase(zero_setup, 0, 15);
        run_phase(full_setup, 20, 0);
        run_phase(rand_setup(1'($urandom), 1'($urandom)), 8, 8);
        run_phase(rand_setup(1'b0, 1'b1), 0, 0);

        // wait for the last results, then idle on for strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_cnt != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input transactions under %0d register setups", items_sent, setups);
        $display("compared %0d results, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
